@@ hdl/lca_pkg.sv @@
// Shared types, codes and constants for the lowest-common-ancestor engine.
// No dependencies; used by the engine's controller, datapath and top level.
`default_nettype none

package lca_pkg;

    localparam int ID_W   = 10;
    localparam int DIST_W = 11;
    localparam int STAT_W = 2;
    localparam int ACT_W  = 2;

    localparam int MAX_NODES_DEF = 1024;
    localparam int LEVELS_DEF    = 10;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BUILD = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ANSWER = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;

    localparam int CMD_W = 5;
    localparam logic [CMD_W-1:0] CMD_IDLE     = 5'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 5'd1;
    localparam logic [CMD_W-1:0] CMD_CAPTURE  = 5'd2;
    localparam logic [CMD_W-1:0] CMD_DECODE   = 5'd3;
    localparam logic [CMD_W-1:0] CMD_DEPTH_B  = 5'd4;
    localparam logic [CMD_W-1:0] CMD_DIFF     = 5'd5;
    localparam logic [CMD_W-1:0] CMD_LIFT_RD  = 5'd6;
    localparam logic [CMD_W-1:0] CMD_LIFT_WB  = 5'd7;
    localparam logic [CMD_W-1:0] CMD_CMP      = 5'd8;
    localparam logic [CMD_W-1:0] CMD_DESC_A   = 5'd9;
    localparam logic [CMD_W-1:0] CMD_DESC_B   = 5'd10;
    localparam logic [CMD_W-1:0] CMD_DESC_UPD = 5'd11;
    localparam logic [CMD_W-1:0] CMD_PAR_RD   = 5'd12;
    localparam logic [CMD_W-1:0] CMD_PAR_WB   = 5'd13;
    localparam logic [CMD_W-1:0] CMD_DL_RD    = 5'd14;
    localparam logic [CMD_W-1:0] CMD_DIST     = 5'd15;
    localparam logic [CMD_W-1:0] CMD_B_RD0    = 5'd16;
    localparam logic [CMD_W-1:0] CMD_B_RD1    = 5'd17;
    localparam logic [CMD_W-1:0] CMD_B_WR     = 5'd18;
    localparam logic [CMD_W-1:0] CMD_EMIT     = 5'd19;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  node_a;
        logic [ID_W-1:0]  node_b;
        logic [ID_W-1:0]  depth_in;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0]   ancestor;
        logic [DIST_W-1:0] distance;
        logic [STAT_W-1:0] status;
    } t_out_word;

    typedef struct packed {
        logic [CMD_W-1:0] op;
    } t_ctl;

    typedef struct packed {
        logic             clr_last;
        logic [ACT_W-1:0] act;
        logic             load_ok;
        logic             query_ok;
        logic             cnt_zero;
        logic             gap_zero;
        logic             a_eq_b;
        logic             lvl_zero;
        logic             build_last;
        logic             out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hdl/tree_ancestor_lca_engine.sv @@
// One word is in work at a time; the ancestor table RAM's single read port sets the pace.
// After reset (synchronous, active low) the table is swept to none
// with input stalled; config writes always taken.
// Top level of the LCA engine; depends on lca_pkg, lca_ctrl, lca_dpath, lca_ram.
`default_nettype none

module tree_ancestor_lca_engine #(
    parameter int MAX_NODES = lca_pkg::MAX_NODES_DEF,
    parameter int LEVELS    = lca_pkg::LEVELS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire lca_pkg::t_in_word        i_in_word,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output lca_pkg::t_out_word            o_out_word,
    input  wire logic                     i_out_stall,
    input  wire logic                     i_cfg_valid,
    input  wire logic [lca_pkg::ID_W-1:0] i_cfg_word,
    output logic                          o_cfg_ready
);

    lca_pkg::t_ctl ctl;
    lca_pkg::t_sts sts;

    lca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    lca_dpath #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_word  (i_cfg_word),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

@@ hdl/lca_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/lca_dpath.sv @@
// Datapath: ancestor table and depth RAMs, work registers, config and output word.
// Depends on lca_pkg and lca_ram; driven by lca_ctrl through t_ctl / t_sts.
`default_nettype none

module lca_dpath #(
    parameter int MAX_NODES = lca_pkg::MAX_NODES_DEF,
    parameter int LEVELS    = lca_pkg::LEVELS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire lca_pkg::t_ctl           i_ctl,
    output lca_pkg::t_sts                o_sts,
    input  wire lca_pkg::t_in_word       i_in_word,
    input  wire logic                    i_cfg_valid,
    input  wire logic [lca_pkg::ID_W-1:0] i_cfg_word,
    output logic                         o_cfg_ready,
    output logic                         o_out_valid,
    output lca_pkg::t_out_word           o_out_word,
    input  wire logic                    i_out_stall
);

    localparam int NW        = $clog2(MAX_NODES);
    localparam int LW        = $clog2(LEVELS + 1);
    localparam int AAW       = NW + LW;
    localparam int ANC_DEPTH = MAX_NODES * (2 ** LW);

    localparam int IDW = lca_pkg::ID_W;
    localparam int DW  = lca_pkg::DIST_W;

    function automatic logic [AAW-1:0] tab_addr(input logic [IDW-1:0] node,
                                                input logic [LW-1:0]  lvl);
        return {NW'(node), lvl};
    endfunction

    // config and output word
    logic [IDW-1:0]      r_node_count;
    logic                r_out_valid;
    lca_pkg::t_out_word  r_out;

    // work registers
    logic [lca_pkg::ACT_W-1:0]  r_act;
    logic [IDW-1:0]             r_a;
    logic [IDW-1:0]             r_b;
    logic [IDW-1:0]             r_din;
    logic [IDW-1:0]             r_da;
    logic [DW-1:0]              r_dsum;
    logic [IDW-1:0]             r_gap;
    logic [LW-1:0]              r_lvl;
    logic [IDW-1:0]             r_idx;
    logic [IDW-1:0]             r_pa;
    logic [IDW-1:0]             r_l;
    logic [IDW-1:0]             r_res_anc;
    logic [DW-1:0]              r_res_dist;
    logic [lca_pkg::STAT_W-1:0] r_res_status;
    logic [AAW-1:0]             r_clr_addr;

    logic [IDW-1:0] cnt;
    logic           load_ok;
    logic           query_ok;
    logic           out_free;
    logic [LW-1:0]  lift_k;
    logic [IDW-1:0] lift_step;
    logic [IDW-1:0] dl;
    logic [DW:0]    diff;
    logic [DW-1:0]  dist_val;

    logic           anc_we;
    logic [AAW-1:0] anc_waddr;
    logic [IDW-1:0] anc_wdata;
    logic [AAW-1:0] anc_raddr;
    logic [IDW-1:0] anc_q;
    logic           dep_we;
    logic [NW-1:0]  dep_raddr;
    logic [IDW-1:0] dep_q;

    assign cnt = (int'(r_node_count) > MAX_NODES - 1) ? IDW'(MAX_NODES - 1) : r_node_count;

    assign load_ok  = (r_a != '0) && (r_a <= cnt) && (r_b <= cnt);
    assign query_ok = (r_a != '0) && (r_a <= cnt) && (r_b != '0) && (r_b <= cnt);
    assign out_free = !r_out_valid || !i_out_stall;

    // largest jump that fits in the remaining gap, capped at the top level
    always_comb begin
        int v_pos;
        v_pos = 0;
        for (int i = 0; i < IDW; i++) begin
            if (r_gap[i]) begin
                v_pos = i;
            end
        end
        if (v_pos > LEVELS) begin
            v_pos = LEVELS;
        end
        lift_k    = LW'(v_pos);
        lift_step = IDW'(1) << v_pos;
    end

    assign dl       = (r_l == '0) ? '0 : dep_q;
    assign diff     = {1'b0, r_dsum} - {1'b0, dl, 1'b0};
    assign dist_val = diff[DW] ? '0 : diff[DW-1:0];

    // ancestor table ports
    always_comb begin
        anc_we    = 1'b0;
        anc_waddr = r_clr_addr;
        anc_wdata = '0;
        anc_raddr = '0;
        case (i_ctl.op)
            lca_pkg::CMD_CLEAR: begin
                anc_we = 1'b1;
            end
            lca_pkg::CMD_DECODE: begin
                anc_we    = (r_act == lca_pkg::ACT_LOAD) && load_ok;
                anc_waddr = tab_addr(r_a, '0);
                anc_wdata = r_b;
            end
            lca_pkg::CMD_LIFT_RD: anc_raddr = tab_addr(r_a, lift_k);
            lca_pkg::CMD_DESC_A:  anc_raddr = tab_addr(r_a, r_lvl);
            lca_pkg::CMD_DESC_B:  anc_raddr = tab_addr(r_b, r_lvl);
            lca_pkg::CMD_PAR_RD:  anc_raddr = tab_addr(r_a, '0);
            lca_pkg::CMD_B_RD0:   anc_raddr = tab_addr(r_idx, r_lvl - LW'(1));
            lca_pkg::CMD_B_RD1:   anc_raddr = tab_addr(anc_q, r_lvl - LW'(1));
            lca_pkg::CMD_B_WR: begin
                anc_we    = 1'b1;
                anc_waddr = tab_addr(r_idx, r_lvl);
                anc_wdata = anc_q;
            end
            default: anc_raddr = '0;
        endcase
    end

    // depth store ports
    always_comb begin
        dep_we = (i_ctl.op == lca_pkg::CMD_DECODE) && (r_act == lca_pkg::ACT_LOAD) && load_ok;
        case (i_ctl.op)
            lca_pkg::CMD_DEPTH_B: dep_raddr = NW'(r_b);
            lca_pkg::CMD_DL_RD:   dep_raddr = NW'(r_l);
            default:              dep_raddr = NW'(r_a);
        endcase
    end

    lca_ram #(
        .WIDTH (IDW),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (anc_we),
        .i_waddr (anc_waddr),
        .i_wdata (anc_wdata),
        .i_raddr (anc_raddr),
        .o_rdata (anc_q)
    );

    lca_ram #(
        .WIDTH (IDW),
        .DEPTH (MAX_NODES)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (NW'(r_a)),
        .i_wdata (r_din),
        .i_raddr (dep_raddr),
        .o_rdata (dep_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= IDW'(1);
            r_out_valid  <= 1'b0;
            r_clr_addr   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_word;
            end
            if (i_ctl.op == lca_pkg::CMD_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.op == lca_pkg::CMD_CLEAR) begin
                r_clr_addr <= r_clr_addr + AAW'(1);
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            lca_pkg::CMD_CAPTURE: begin
                r_act <= i_in_word.action;
                r_a   <= i_in_word.node_a;
                r_b   <= i_in_word.node_b;
                r_din <= i_in_word.depth_in;
            end
            lca_pkg::CMD_DECODE: begin
                r_res_anc  <= '0;
                r_res_dist <= '0;
                r_lvl      <= LW'(1);
                r_idx      <= IDW'(1);
                case (r_act)
                    lca_pkg::ACT_LOAD:  r_res_status <= load_ok ? lca_pkg::ST_DONE
                                                                : lca_pkg::ST_RANGE;
                    lca_pkg::ACT_QUERY: r_res_status <= query_ok ? lca_pkg::ST_ANSWER
                                                                 : lca_pkg::ST_RANGE;
                    default:            r_res_status <= lca_pkg::ST_DONE;
                endcase
            end
            lca_pkg::CMD_DEPTH_B: r_da <= dep_q;
            lca_pkg::CMD_DIFF: begin
                r_dsum <= DW'(r_da) + DW'(dep_q);
                if (r_da < dep_q) begin
                    r_a   <= r_b;
                    r_b   <= r_a;
                    r_gap <= dep_q - r_da;
                end else begin
                    r_gap <= r_da - dep_q;
                end
            end
            lca_pkg::CMD_LIFT_RD: r_gap <= r_gap - lift_step;
            lca_pkg::CMD_LIFT_WB: r_a <= anc_q;
            lca_pkg::CMD_CMP: begin
                r_lvl <= LW'(LEVELS);
                r_l   <= r_a;
            end
            lca_pkg::CMD_DESC_B: r_pa <= anc_q;
            lca_pkg::CMD_DESC_UPD: begin
                if ((r_pa != '0) && (r_pa != anc_q)) begin
                    r_a <= r_pa;
                    r_b <= anc_q;
                end
                if (r_lvl != '0) begin
                    r_lvl <= r_lvl - LW'(1);
                end
            end
            lca_pkg::CMD_PAR_WB: r_l <= anc_q;
            lca_pkg::CMD_DIST: begin
                r_res_anc    <= r_l;
                r_res_dist   <= dist_val;
                r_res_status <= lca_pkg::ST_ANSWER;
            end
            lca_pkg::CMD_B_WR: begin
                if (r_idx == cnt) begin
                    r_idx <= IDW'(1);
                    r_lvl <= r_lvl + LW'(1);
                end else begin
                    r_idx <= r_idx + IDW'(1);
                end
            end
            lca_pkg::CMD_EMIT: begin
                r_out.ancestor <= r_res_anc;
                r_out.distance <= r_res_dist;
                r_out.status   <= r_res_status;
            end
            default: ;
        endcase
    end

    assign o_sts.clr_last   = (r_clr_addr == AAW'(ANC_DEPTH - 1));
    assign o_sts.act        = r_act;
    assign o_sts.load_ok    = load_ok;
    assign o_sts.query_ok   = query_ok;
    assign o_sts.cnt_zero   = (cnt == '0);
    assign o_sts.gap_zero   = (r_gap == '0);
    assign o_sts.a_eq_b     = (r_a == r_b);
    assign o_sts.lvl_zero   = (r_lvl == '0);
    assign o_sts.build_last = (r_idx == cnt) && (r_lvl == LW'(LEVELS));
    assign o_sts.out_free   = out_free;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == lca_pkg::CMD_EMIT) |-> out_free)
        else $error("result word loaded while output still held");

    a_non_answer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != lca_pkg::ST_ANSWER))
            |-> ((r_out.ancestor == '0) && (r_out.distance == '0)))
        else $error("non-query word carries ancestor or distance");

    a_row0_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (anc_we && (i_ctl.op != lca_pkg::CMD_CLEAR)) |-> (anc_waddr[AAW-1:LW] != '0))
        else $error("write to the none row of the ancestor table");

    a_build_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == lca_pkg::CMD_B_WR) |-> ((r_lvl != '0) && (r_idx != '0)))
        else $error("build writes level zero or node zero");
`endif

endmodule

`default_nettype wire

@@ hdl/lca_ctrl.sv @@
// Controller FSM: sequences clear, load, build and query steps in the datapath.
// Depends on lca_pkg; talks to lca_dpath through t_ctl / t_sts only.
`default_nettype none

module lca_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lca_pkg::t_sts i_sts,
    output lca_pkg::t_ctl      o_ctl
);

    localparam int SW = 5;
    localparam logic [SW-1:0] S_CLEAR   = 5'd0;
    localparam logic [SW-1:0] S_IDLE    = 5'd1;
    localparam logic [SW-1:0] S_DECODE  = 5'd2;
    localparam logic [SW-1:0] S_Q_DB    = 5'd3;
    localparam logic [SW-1:0] S_Q_DIFF  = 5'd4;
    localparam logic [SW-1:0] S_LIFT    = 5'd5;
    localparam logic [SW-1:0] S_LIFT_WB = 5'd6;
    localparam logic [SW-1:0] S_CMP     = 5'd7;
    localparam logic [SW-1:0] S_DESC_A  = 5'd8;
    localparam logic [SW-1:0] S_DESC_B  = 5'd9;
    localparam logic [SW-1:0] S_DESC_U  = 5'd10;
    localparam logic [SW-1:0] S_PAR     = 5'd11;
    localparam logic [SW-1:0] S_PAR_WB  = 5'd12;
    localparam logic [SW-1:0] S_DL      = 5'd13;
    localparam logic [SW-1:0] S_DL_WB   = 5'd14;
    localparam logic [SW-1:0] S_B_RD0   = 5'd15;
    localparam logic [SW-1:0] S_B_RD1   = 5'd16;
    localparam logic [SW-1:0] S_B_WR    = 5'd17;
    localparam logic [SW-1:0] S_FINISH  = 5'd18;

    logic [SW-1:0] r_state;
    logic [SW-1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_ctl.op  = lca_pkg::CMD_IDLE;
        case (r_state)
            S_CLEAR: begin
                o_ctl.op = lca_pkg::CMD_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.op = lca_pkg::CMD_CAPTURE;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                o_ctl.op = lca_pkg::CMD_DECODE;
                case (i_sts.act)
                    lca_pkg::ACT_BUILD: n_state = i_sts.cnt_zero ? S_FINISH : S_B_RD0;
                    lca_pkg::ACT_QUERY: n_state = i_sts.query_ok ? S_Q_DB : S_FINISH;
                    default:            n_state = S_FINISH;
                endcase
            end
            S_Q_DB: begin
                o_ctl.op = lca_pkg::CMD_DEPTH_B;
                n_state  = S_Q_DIFF;
            end
            S_Q_DIFF: begin
                o_ctl.op = lca_pkg::CMD_DIFF;
                n_state  = S_LIFT;
            end
            S_LIFT: begin
                if (i_sts.gap_zero) begin
                    n_state = S_CMP;
                end else begin
                    o_ctl.op = lca_pkg::CMD_LIFT_RD;
                    n_state  = S_LIFT_WB;
                end
            end
            S_LIFT_WB: begin
                o_ctl.op = lca_pkg::CMD_LIFT_WB;
                n_state  = S_LIFT;
            end
            S_CMP: begin
                o_ctl.op = lca_pkg::CMD_CMP;
                n_state  = i_sts.a_eq_b ? S_DL : S_DESC_A;
            end
            S_DESC_A: begin
                o_ctl.op = lca_pkg::CMD_DESC_A;
                n_state  = S_DESC_B;
            end
            S_DESC_B: begin
                o_ctl.op = lca_pkg::CMD_DESC_B;
                n_state  = S_DESC_U;
            end
            S_DESC_U: begin
                o_ctl.op = lca_pkg::CMD_DESC_UPD;
                n_state  = i_sts.lvl_zero ? S_PAR : S_DESC_A;
            end
            S_PAR: begin
                o_ctl.op = lca_pkg::CMD_PAR_RD;
                n_state  = S_PAR_WB;
            end
            S_PAR_WB: begin
                o_ctl.op = lca_pkg::CMD_PAR_WB;
                n_state  = S_DL;
            end
            S_DL: begin
                o_ctl.op = lca_pkg::CMD_DL_RD;
                n_state  = S_DL_WB;
            end
            S_DL_WB: begin
                o_ctl.op = lca_pkg::CMD_DIST;
                n_state  = S_FINISH;
            end
            S_B_RD0: begin
                o_ctl.op = lca_pkg::CMD_B_RD0;
                n_state  = S_B_RD1;
            end
            S_B_RD1: begin
                o_ctl.op = lca_pkg::CMD_B_RD1;
                n_state  = S_B_WR;
            end
            S_B_WR: begin
                o_ctl.op = lca_pkg::CMD_B_WR;
                n_state  = i_sts.build_last ? S_FINISH : S_B_RD0;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_ctl.op = lca_pkg::CMD_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire
